[hw/rtl/pkd_pkg.sv]
// ----------------------------------------------------------------------------
// pkd_pkg: shared types and helpers for the position-keyed byte descrambler
// Beat types, result queue sizing and the per-byte bit permutations.
// ----------------------------------------------------------------------------
package pkd_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] MOD3_LAST = 2'd2;
  localparam logic [2:0] MOD5_LAST = 3'd4;
  localparam logic [2:0] MOD7_LAST = 3'd6;

  localparam logic [2:0] MOD5_PAIR_HEAD = 3'd0;
  localparam logic [2:0] MOD5_PAIR_TAIL = 3'd1;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       final_byte;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] count;
    out_beat_t  first;
    out_beat_t  second;
  } push_t;

  typedef struct packed {
    logic              room_for_two;
    logic [QCNT_W-1:0] level;
  } q_status_t;

  function automatic logic [7:0] bit_reverse(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7 - k] = b[k];
    end
    return r;
  endfunction

  function automatic logic [7:0] swap_bits_3_4(input logic [7:0] b);
    return {b[7:5], b[3], b[4], b[2:0]};
  endfunction

endpackage

[hw/rtl/pkd_core.sv]
// ----------------------------------------------------------------------------
// pkd_core: position tracking and per-byte descrambling
// Applies the position-keyed permutations, holds the byte at each pair head
// and emits zero, one or two result beats for every accepted input beat.
// ----------------------------------------------------------------------------
module pkd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  pkd_pkg::in_beat_t in_beat,
  output pkd_pkg::push_t    push
);

  logic       mod2_r, mod2_nxt;
  logic [1:0] mod3_r, mod3_nxt;
  logic [2:0] mod5_r, mod5_nxt;
  logic [2:0] mod7_r, mod7_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;

  logic [7:0] b_rev, b_inv, b_out;
  logic       last;

  assign last  = in_beat.end_of_buffer;
  assign b_rev = (mod2_r == 1'b0) ? pkd_pkg::bit_reverse(in_beat.data_byte) : in_beat.data_byte;
  assign b_inv = (mod7_r == 3'd0) ? ~b_rev : b_rev;
  assign b_out = (mod3_r == 2'd0) ? pkd_pkg::swap_bits_3_4(b_inv) : b_inv;

  always_comb begin
    push           = '0;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    mod2_nxt       = mod2_r;
    mod3_nxt       = mod3_r;
    mod5_nxt       = mod5_r;
    mod7_nxt       = mod7_r;
    if (accept) begin
      if (mod5_r == pkd_pkg::MOD5_PAIR_HEAD) begin
        if (last) begin
          push.count  = pkd_pkg::PUSH_ONE;
          push.first  = '{plain_byte: b_out, final_byte: 1'b1};
        end else begin
          held_byte_nxt  = b_out;
          held_valid_nxt = 1'b1;
        end
      end else if (mod5_r == pkd_pkg::MOD5_PAIR_TAIL && held_valid_r) begin
        push.count     = pkd_pkg::PUSH_TWO;
        push.first     = '{plain_byte: {b_out[7], held_byte_r[6:0]}, final_byte: 1'b0};
        push.second    = '{plain_byte: {held_byte_r[7], b_out[6:0]}, final_byte: last};
        held_valid_nxt = 1'b0;
      end else begin
        push.count = pkd_pkg::PUSH_ONE;
        push.first = '{plain_byte: b_out, final_byte: last};
      end

      if (last) begin
        mod2_nxt       = 1'b0;
        mod3_nxt       = 2'd0;
        mod5_nxt       = 3'd0;
        mod7_nxt       = 3'd0;
        held_valid_nxt = 1'b0;
      end else begin
        mod2_nxt = ~mod2_r;
        mod3_nxt = (mod3_r >= pkd_pkg::MOD3_LAST) ? 2'd0 : mod3_r + 2'd1;
        mod5_nxt = (mod5_r >= pkd_pkg::MOD5_LAST) ? 3'd0 : mod5_r + 3'd1;
        mod7_nxt = (mod7_r >= pkd_pkg::MOD7_LAST) ? 3'd0 : mod7_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod2_r       <= 1'b0;
      mod3_r       <= 2'd0;
      mod5_r       <= 3'd0;
      mod7_r       <= 3'd0;
      held_valid_r <= 1'b0;
    end else begin
      mod2_r       <= mod2_nxt;
      mod3_r       <= mod3_nxt;
      mod5_r       <= mod5_nxt;
      mod7_r       <= mod7_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

endmodule

[hw/rtl/pkd_outq.sv]
// ----------------------------------------------------------------------------
// pkd_outq: result queue
// Small register queue that takes up to two beats per cycle and presents one
// registered beat per cycle on the result channel while out_stall is low.
// ----------------------------------------------------------------------------
module pkd_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  pkd_pkg::push_t      push,
  output pkd_pkg::q_status_t  status,
  output logic                out_valid,
  input  logic                out_stall,
  output pkd_pkg::out_beat_t  out_data
);

  pkd_pkg::out_beat_t mem [pkd_pkg::QDEPTH];

  logic [pkd_pkg::QPTR_W-1:0] rd_r, rd_nxt;
  logic [pkd_pkg::QPTR_W-1:0] wr_r, wr_nxt;
  logic [pkd_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem[rd_r];
  assign pop       = out_valid && !out_stall;

  assign rd_nxt  = rd_r + pkd_pkg::QPTR_W'(pop);
  assign wr_nxt  = wr_r + pkd_pkg::QPTR_W'(push.count);
  assign cnt_nxt = cnt_r + pkd_pkg::QCNT_W'(push.count) - pkd_pkg::QCNT_W'(pop);

  assign status.level        = cnt_r;
  assign status.room_for_two = (cnt_r <= pkd_pkg::QCNT_W'(pkd_pkg::QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != pkd_pkg::PUSH_NONE) begin
      mem[wr_r] <= push.first;
    end
    if (push.count == pkd_pkg::PUSH_TWO) begin
      mem[pkd_pkg::QPTR_W'(wr_r + 1'b1)] <= push.second;
    end
  end

endmodule

[hw/rtl/position_keyed_byte_descrambler.sv]
// ----------------------------------------------------------------------------
// position_keyed_byte_descrambler: top level
// Descrambles a byte buffer by byte position and returns it in buffer order.
// ----------------------------------------------------------------------------
//  Channel  Ports                          Beat
//  in       in_valid, in_stall, in_data    one scrambled byte, end mark
//  out      out_valid, out_stall, out_data one plain byte, final mark
//
// Under free flow one input beat is taken and one result leaves per cycle,
// via a four-entry result queue. A pair-head byte gives no beat unless it
// ends the buffer and its partner gives two, so the queue level then stays at
// two or less. in_stall rises only when the queue cannot take two more beats.
// Synchronous reset clears the position counters, the hold and the queue.
module position_keyed_byte_descrambler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pkd_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pkd_pkg::out_beat_t  out_data
);

  pkd_pkg::push_t     push;
  pkd_pkg::q_status_t q_status;
  logic               in_accept;

  assign in_stall  = !q_status.room_for_two;
  assign in_accept = in_valid && !in_stall;

  pkd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_beat (in_data),
    .push    (push)
  );

  pkd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .status    (q_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_level_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_status.level <= pkd_pkg::QCNT_W'(pkd_pkg::QDEPTH))
    else $error("result queue level exceeds its depth");

  a_marked_yields : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.end_of_buffer) |-> (push.count != pkd_pkg::PUSH_NONE))
    else $error("marked byte produced no result beat");

  a_push_shows : assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != pkd_pkg::PUSH_NONE) |=> out_valid)
    else $error("pushed result beat not presented");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result channel valid right after reset");
`endif

endmodule
